// ----- hdl/efr_pkg.sv -----
// Package for the ESC/STX/ETX frame receiver: register indexes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END    = 2'd2;

    localparam logic [7:0] ESCAPE_RESET = 8'd27;
    localparam logic [7:0] START_RESET  = 8'd2;
    localparam logic [7:0] END_RESET    = 8'd3;

    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } efr_state_t;

    typedef struct packed {
        logic accept;   // input transaction this cycle
        logic fetch;    // read the store at the drain counter
        logic load;     // load the output register and advance the drain counter
    } efr_cmd_t;

    typedef struct packed {
        logic frame_done;   // byte being accepted closes a frame
        logic slot_free;    // output register empty or being taken
        logic rd_last;      // drain counter sits on the final byte
    } efr_status_t;

endpackage

`default_nettype wire

// ----- hdl/efr_datapath.sv -----
// Datapath of the frame receiver: configuration registers, frame store,
// framing checks, drain counter and output register. Uses efr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efr_datapath #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [efr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [efr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [7:0]                         rx_byte,
    input  wire efr_pkg::efr_cmd_t                  cmd,
    output efr_pkg::efr_status_t                    status,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic [efr_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                    m_tlast
);
    import efr_pkg::*;

    localparam int unsigned IW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

    logic [7:0] escape_reg;
    logic [7:0] start_reg;
    logic [7:0] end_reg;

    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    logic [IW-1:0] fill_reg;
    logic [IW-1:0] fill_next;
    logic [7:0]    b0_reg;
    logic [7:0]    b1_reg;
    logic [7:0]    prev_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] rd_cnt_reg;

    logic          m_valid_reg;
    logic [7:0]    m_byte_reg;
    logic          m_last_reg;
    logic [5:0]    m_len_reg;

    logic          is_first;
    logic          is_second;
    logic [7:0]    s1;
    logic [7:0]    pm2;
    logic          drop;
    logic          restart;
    logic          done;
    logic [CW-1:0] n;
    logic [CW-1:0] n_eff;
    logic [CW+5:0] len_ext;
    logic [7:0]    drain_byte;

    // Framing checks on the byte being offered
    always_comb begin
        is_first  = (fill_reg == '0);
        is_second = (fill_reg == IW'(1));
        n         = CW'(fill_reg) + CW'(1);
        s1        = is_second ? rx_byte : b1_reg;
        drop      = (is_first && rx_byte != escape_reg)
                 || (is_second && rx_byte != start_reg)
                 || (!is_first && b0_reg != escape_reg && s1 != start_reg)
                 || (fill_reg == IW'(STORE_DEPTH - 1));
        restart   = !drop && !is_first && !is_second
                 && prev_reg == escape_reg && rx_byte == start_reg;
        pm2       = restart ? escape_reg : prev_reg;
        done      = !drop && !is_first && pm2 == escape_reg && rx_byte == end_reg;
        n_eff     = restart ? CW'(2) : n;
        fill_next = (drop || done) ? '0 : n_eff[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= ESCAPE_RESET;
            start_reg  <= START_RESET;
            end_reg    <= END_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ESCAPE: escape_reg <= cfg_wdata;
                REG_START:  start_reg  <= cfg_wdata;
                REG_END:    end_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame store: written on accept, read during drain
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            store_mem[fill_reg] <= rx_byte;
        end
        if (cmd.fetch) begin
            rdata_reg <= store_mem[rd_cnt_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            prev_reg <= rx_byte;
            if (restart) begin
                b0_reg <= escape_reg;
                b1_reg <= start_reg;
            end else begin
                if (is_first) begin
                    b0_reg <= rx_byte;
                end
                if (is_second) begin
                    b1_reg <= rx_byte;
                end
            end
            if (done) begin
                len_reg <= n_eff;
            end
        end
    end

    // Opening pair is kept in registers; the rest comes from the store
    always_comb begin
        priority if (rd_cnt_reg == '0) begin
            drain_byte = b0_reg;
        end else if (rd_cnt_reg == CW'(1)) begin
            drain_byte = b1_reg;
        end else begin
            drain_byte = rdata_reg;
        end
    end

    assign len_ext = {6'd0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg <= '0;
        end else if (cmd.accept) begin
            rd_cnt_reg <= '0;
        end else if (cmd.load) begin
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_byte_reg <= drain_byte;
            m_len_reg  <= len_ext[5:0];
            m_last_reg <= status.rd_last;
        end
    end

    assign status.frame_done = done;
    assign status.slot_free  = !m_valid_reg || m_tready;
    assign status.rd_last    = (rd_cnt_reg + CW'(1)) == len_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_len_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- hdl/efr_ctrl.sv -----
// Controller of the frame receiver: takes bytes while idle and sequences
// the drain of a completed frame. Uses efr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efr_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire efr_pkg::efr_status_t   status,
    output efr_pkg::efr_cmd_t           cmd
);
    import efr_pkg::*;

    efr_state_t state_reg;
    efr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.frame_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (status.slot_free) begin
                    state_next = status.rd_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.fetch  = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            ST_SEND: begin
                // hold the byte until the output register can take it
                cmd.load = status.slot_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/esc_stx_etx_frame_receiver.sv -----
// Top level of the ESC/STX/ETX frame receiver: joins controller and datapath.
// Depends on efr_pkg, efr_ctrl and efr_datapath.
//
// Usage:
//   Received bytes enter on the s_ channel, one per transaction. A frame
//   opens with the escape byte then the start byte; a wrong opening byte or
//   a full store drops the bytes gathered so far. A later escape/start pair
//   restarts the frame, an escape/end pair completes it.
//   A completed frame leaves on the m_ channel, one byte per transaction,
//   framing included, with its length in every transaction and tlast on
//   its final byte.
//   Throughput: one input byte per cycle while no frame completes. The byte
//   that completes a frame starts the drain, which takes one byte at a time,
//   a store read in ST_FETCH then an output register load in ST_SEND, with
//   s_tready low throughout, as the store has a single read port.
//   After the closing byte, the first frame byte goes through these two states.
//   Stall: a low m_tready holds the output register and pauses the drain;
//   input reopens once the final byte is in the output register.
//   Reset: synchronous, active low; restores the register defaults (27, 2, 3)
//   and drops any gathered bytes. Configuration writes take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module esc_stx_etx_frame_receiver #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [efr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [efr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] rx_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] frame_byte, [13:8] frame_length, [15:14] zero
    output logic [efr_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                    m_tlast    // frame_last
);
    import efr_pkg::*;

    efr_cmd_t    cmd;
    efr_status_t status;

    efr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    efr_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A completing byte closes the input until the frame has drained
    a_done_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && status.frame_done |=> !s_tready)
        else $error("input open after frame completion");

    // A load always presents a transaction on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_tvalid)
        else $error("loaded byte not presented");

    // Loading the final byte reopens the input
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && status.rd_last |=> s_tready && m_tlast)
        else $error("input not reopened after final byte");

    // Store reads and input never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |-> !s_tready && !cmd.load)
        else $error("store read overlaps input or load");

endmodule

`default_nettype wire
